// ===== hdl/gda_pkg.sv =====
package gda_pkg;

    // Field widths
    localparam int YEAR_IN_W  = 15;
    localparam int YEAR_OUT_W = 16;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int ADD_W      = 15;
    localparam int REM_W      = 16;   // day ordinal plus day count, at most 33133
    localparam int QUO_W      = 9;    // start year / 100, at most 327
    localparam int R100_W     = 7;
    localparam int PC_W       = 4;

    // Reciprocal of 100 for years below 2^15: q = (y * RECIP_100) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam logic [R100_W-1:0] HUNDRED = 7'd100;
    localparam logic [R100_W-1:0] R100_LAST = 7'd99;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [8:0] YEAR_LEN_LEAP = 9'd366;
    localparam logic [8:0] YEAR_LEN_NORM = 9'd365;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIVQ,
        OP_DIVR,
        OP_ORD,
        OP_YEAR,
        OP_MRST,
        OP_MONTH,
        OP_EMIT,
        OP_EMIT_BAD
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_OUT_FREE,
        COND_BAD,
        COND_M_LT_START,
        COND_YEAR_STEP,
        COND_MONTH_STEP
    } cond_t;

    // One control word: op runs and pc jumps to target when cond holds,
    // otherwise pc holds or advances
    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            hold;
    } uword_t;

    // Flags from the datapath to the sequencer
    typedef struct packed {
        logic bad;
        logic m_lt_start;
        logic year_step;
        logic month_step;
    } dp_flags_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        op_t  op;
        logic in_ready;
    } ctrl_t;

    // Step addresses
    localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] STEP_DIVQ     = 4'd1;
    localparam logic [PC_W-1:0] STEP_DIVR     = 4'd2;
    localparam logic [PC_W-1:0] STEP_CHECK    = 4'd3;
    localparam logic [PC_W-1:0] STEP_ORD      = 4'd4;
    localparam logic [PC_W-1:0] STEP_YEAR     = 4'd5;
    localparam logic [PC_W-1:0] STEP_MRST     = 4'd6;
    localparam logic [PC_W-1:0] STEP_MONTH    = 4'd7;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd8;
    localparam logic [PC_W-1:0] STEP_EMIT_BAD = 4'd9;
    localparam logic [PC_W-1:0] STEP_LAST     = STEP_EMIT_BAD;

    // Month length; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Control store
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            STEP_WAIT:     w = '{OP_LOAD,     COND_IN_VALID,   STEP_DIVQ,  1'b1};
            STEP_DIVQ:     w = '{OP_DIVQ,     COND_ALWAYS,     STEP_DIVR,  1'b0};
            STEP_DIVR:     w = '{OP_DIVR,     COND_ALWAYS,     STEP_CHECK, 1'b0};
            STEP_CHECK:    w = '{OP_NOP,      COND_BAD,        STEP_EMIT_BAD, 1'b0};
            STEP_ORD:      w = '{OP_ORD,      COND_M_LT_START, STEP_ORD,   1'b0};
            STEP_YEAR:     w = '{OP_YEAR,     COND_YEAR_STEP,  STEP_YEAR,  1'b0};
            STEP_MRST:     w = '{OP_MRST,     COND_ALWAYS,     STEP_MONTH, 1'b0};
            STEP_MONTH:    w = '{OP_MONTH,    COND_MONTH_STEP, STEP_MONTH, 1'b0};
            STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_FREE,   STEP_WAIT,  1'b1};
            STEP_EMIT_BAD: w = '{OP_EMIT_BAD, COND_OUT_FREE,   STEP_WAIT,  1'b1};
            default:       w = '{OP_NOP,      COND_ALWAYS,     STEP_WAIT,  1'b0};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/gda_sequencer.sv =====
module gda_sequencer
    import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    input  dp_flags_t flags,
    output ctrl_t     ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;
    logic            taken;

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Decode the current word and pick the next step
    always_comb
    begin
        word = ucode(pc_reg);
        unique case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_IN_VALID:   taken = in_valid;
            COND_OUT_FREE:   taken = out_free;
            COND_BAD:        taken = flags.bad;
            COND_M_LT_START: taken = flags.m_lt_start;
            COND_YEAR_STEP:  taken = flags.year_step;
            COND_MONTH_STEP: taken = flags.month_step;
            default:         taken = 1'b1;
        endcase
        if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
        ctrl.op       = taken ? word.op : OP_NOP;
        ctrl.in_ready = (word.op == OP_LOAD);
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_LAST)
        else $error("step counter beyond program");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.in_ready && in_valid) |=> pc_reg == STEP_DIVQ)
        else $error("accepted request did not start the program");

endmodule

// ===== hdl/gda_datapath.sv =====
module gda_datapath
    import gda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 ctrl,
    input  logic [YEAR_IN_W-1:0]  start_year,
    input  logic [MONTH_W-1:0]    start_month,
    input  logic [DAY_W-1:0]      start_day,
    input  logic [ADD_W-1:0]      days_to_add,
    output dp_flags_t             flags,
    output logic [YEAR_OUT_W-1:0] res_year,
    output logic [MONTH_W-1:0]    res_month,
    output logic [DAY_W-1:0]      res_day
);

    logic [YEAR_OUT_W-1:0] year_reg,  year_next;
    logic [MONTH_W-1:0]    smonth_reg, smonth_next;
    logic [DAY_W-1:0]      sday_reg,  sday_next;
    logic [ADD_W-1:0]      add_reg,   add_next;
    logic [QUO_W-1:0]      quo_reg,   quo_next;
    logic [R100_W-1:0]     r100_reg,  r100_next;
    logic [1:0]            q4_reg,    q4_next;
    logic [MONTH_W-1:0]    m_reg,     m_next;
    logic [REM_W-1:0]      rem_reg,   rem_next;

    logic [30:0]           prod;
    logic [YEAR_OUT_W-1:0] quo_x100;
    logic [YEAR_OUT_W-1:0] year_mod;
    logic                  leap;
    logic [8:0]            year_len;
    logic [DAY_W-1:0]      cur_mlen;
    logic [DAY_W-1:0]      start_mlen;

    // Payload registers
    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        smonth_reg <= smonth_next;
        sday_reg   <= sday_next;
        add_reg    <= add_next;
        quo_reg    <= quo_next;
        r100_reg   <= r100_next;
        q4_reg     <= q4_next;
        m_reg      <= m_next;
        rem_reg    <= rem_next;
    end

    // Leap status of the current year from its remainder and quotient by 100
    always_comb
    begin
        leap       = (year_reg[1:0] == 2'd0) && ((r100_reg != '0) || (q4_reg == 2'd0));
        year_len   = leap ? YEAR_LEN_LEAP : YEAR_LEN_NORM;
        cur_mlen   = month_len(m_reg, leap);
        start_mlen = month_len(smonth_reg, leap);
        prod       = 31'(year_reg[YEAR_IN_W-1:0]) * 31'(RECIP_100);
        quo_x100   = YEAR_OUT_W'(quo_reg) * YEAR_OUT_W'(HUNDRED);
        year_mod   = year_reg - quo_x100;
    end

    // Flags for the sequencer
    always_comb
    begin
        flags.bad        = (smonth_reg == '0) || (smonth_reg > MONTH_DEC) ||
                           (sday_reg == '0) || (sday_reg > start_mlen);
        flags.m_lt_start = (m_reg < smonth_reg);
        flags.year_step  = (REM_W'(year_len) < rem_reg);
        flags.month_step = (REM_W'(cur_mlen) < rem_reg) && (m_reg < MONTH_DEC);
    end

    // Execute the current operation
    always_comb
    begin
        year_next   = year_reg;
        smonth_next = smonth_reg;
        sday_next   = sday_reg;
        add_next    = add_reg;
        quo_next    = quo_reg;
        r100_next   = r100_reg;
        q4_next     = q4_reg;
        m_next      = m_reg;
        rem_next    = rem_reg;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                year_next   = YEAR_OUT_W'(start_year);
                smonth_next = start_month;
                sday_next   = start_day;
                add_next    = days_to_add;
            end
            OP_DIVQ:
            begin
                quo_next = prod[RECIP_SHIFT +: QUO_W];
            end
            OP_DIVR:
            begin
                r100_next = year_mod[R100_W-1:0];
                q4_next   = quo_reg[1:0];
                m_next    = MONTH_W'(1);
                rem_next  = REM_W'(sday_reg) + REM_W'(add_reg);
            end
            OP_ORD:
            begin
                rem_next = rem_reg + REM_W'(cur_mlen);
                m_next   = m_reg + 1'b1;
            end
            OP_YEAR:
            begin
                rem_next  = rem_reg - REM_W'(year_len);
                year_next = year_reg + 1'b1;
                if (r100_reg == R100_LAST)
                begin
                    r100_next = '0;
                    q4_next   = q4_reg + 1'b1;
                end
                else
                begin
                    r100_next = r100_reg + 1'b1;
                end
            end
            OP_MRST:
            begin
                m_next = MONTH_W'(1);
            end
            OP_MONTH:
            begin
                rem_next = rem_reg - REM_W'(cur_mlen);
                m_next   = m_reg + 1'b1;
            end
            OP_NOP, OP_EMIT, OP_EMIT_BAD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result fields; the bad path echoes the start date
    always_comb
    begin
        res_year = year_reg;
        if (ctrl.op == OP_EMIT_BAD)
        begin
            res_month = smonth_reg;
            res_day   = sday_reg;
        end
        else
        begin
            res_month = m_reg;
            res_day   = rem_reg[DAY_W-1:0];
        end
    end

    a_year_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_YEAR |=> year_reg == $past(year_reg) + 1'b1)
        else $error("year did not advance on a year step");

    a_r100_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_YEAR |=> r100_reg < HUNDRED)
        else $error("year remainder by 100 out of range");

endmodule

// ===== hdl/gregorian_date_add_days.sv =====
// Channel   Dir  Fields (tdata from bit 0 up)                        Extra
// s_axis    in   start_year[14:0] start_month[18:15] start_day[23:19]  -
//                days_to_add[38:24], bit 39 zero
// m_axis    out  end_year[15:0] end_month[19:16] end_day[24:20],      tuser: bad_input
//                bits 31:25 zero
//
// One request at a time: the program loads, divides, takes the remainder and checks, then sums
// the months before the start month, steps off whole years, then whole months, and emits.
// An invalid start date skips the stepping and goes from the check straight to emitting.
// The result waits in an output register, so a new request is taken while it waits;
// the program stalls at its emit step only while the previous result is still unread.
// Reset (rst_n, asynchronous) returns the program to its wait step and empties the output.
module gregorian_date_add_days
    import gda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // start_year, start_month, start_day, days_to_add
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // end_year, end_month, end_day
    output logic        m_axis_tuser    // bad_input
);

    ctrl_t                 ctrl;
    dp_flags_t             flags;
    logic                  out_free;
    logic [YEAR_OUT_W-1:0] res_year;
    logic [MONTH_W-1:0]    res_month;
    logic [DAY_W-1:0]      res_day;
    logic                  emit;

    logic                  out_valid_reg, out_valid_next;
    logic [YEAR_OUT_W-1:0] out_year_reg,  out_year_next;
    logic [MONTH_W-1:0]    out_month_reg, out_month_next;
    logic [DAY_W-1:0]      out_day_reg,   out_day_next;
    logic                  out_bad_reg,   out_bad_next;

    gda_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    gda_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .start_year  (s_axis_tdata[14:0]),
        .start_month (s_axis_tdata[18:15]),
        .start_day   (s_axis_tdata[23:19]),
        .days_to_add (s_axis_tdata[38:24]),
        .flags       (flags),
        .res_year    (res_year),
        .res_month   (res_month),
        .res_day     (res_day)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = (ctrl.op == OP_EMIT) || (ctrl.op == OP_EMIT_BAD);

    // Output register: load on emit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_bad_next   = out_bad_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_year_next  = res_year;
            out_month_next = res_month;
            out_day_next   = res_day;
            out_bad_next   = (ctrl.op == OP_EMIT_BAD);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_bad_reg   <= out_bad_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_day_reg, out_month_reg, out_year_reg};
    assign m_axis_tuser  = out_bad_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || m_axis_tready))
        else $error("result written over an unread result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gda_pkg::*;

    localparam int IDLE_LIMIT    = 4000;  // cycles with no request or result taken
    localparam int SETTLE_CYCLES = 300;   // beyond the longest date walk
    localparam int RANDOM_DATES  = 1400;
    localparam int MAX_GAP       = 14;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        logic [YEAR_IN_W-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [ADD_W-1:0]     days;
        int unsigned          gap;
        bit                   drain;
    } date_request_t;

    typedef struct {
        logic [YEAR_OUT_W-1:0] year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic                  bad;
        int unsigned           seq;
    } date_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // start_year, start_month, start_day, days_to_add
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // end_year, end_month, end_day
    logic        m_axis_tuser;          // bad_input

    date_request_t pending[$];
    date_result_t  expected_dates[$];
    date_request_t on_bus;
    int unsigned   held_cycles;
    int unsigned   requests_taken;
    int unsigned   stall_left;
    int unsigned   idle_cycles;
    int unsigned   error_count;
    bit            send_quiet;
    bit            recv_quiet;

    gregorian_date_add_days uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Gregorian leap rule: every 400th year, else every 4th but not every 100th
    function automatic bit is_leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            MONTH_FEB:             len = is_leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // Walk the date forward: whole years first, then whole months
    function automatic date_result_t date_after_days(date_request_t req);
        date_result_t r;
        int unsigned  year;
        int unsigned  mon;
        int unsigned  left;
        year = req.year;
        r.seq = 0;
        if (req.month < 1 || req.month > MONTH_DEC || req.day == 0 ||
            req.day > days_in_month(req.month, year)) begin
            r.year  = {1'b0, req.year};
            r.month = req.month;
            r.day   = req.day;
            r.bad   = 1'b1;
            return r;
        end
        left = req.day;
        for (mon = 1; mon < req.month; mon++)
            left += days_in_month(mon, year);
        left += req.days;
        while (left > (is_leap_year(year) ? 366 : 365)) begin
            left -= is_leap_year(year) ? 366 : 365;
            year++;
        end
        mon = 1;
        while (mon < MONTH_DEC && left > days_in_month(mon, year)) begin
            left -= days_in_month(mon, year);
            mon++;
        end
        r.year  = YEAR_OUT_W'(year);
        r.month = MONTH_W'(mon);
        r.day   = DAY_W'(left);
        r.bad   = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_date(input int unsigned y, input int unsigned m,
                              input int unsigned d, input int unsigned n,
                              input bit drain);
        date_request_t req;
        if ($urandom_range(0, 29) == 0)
            send_quiet = ~send_quiet;
        req.year  = YEAR_IN_W'(y);
        req.month = MONTH_W'(m);
        req.day   = DAY_W'(d);
        req.days  = ADD_W'(n);
        req.gap   = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        req.drain = drain;
        pending.push_back(req);
    endtask

    // Random date and day count, mostly valid and biased to the awkward years
    task automatic queue_random_date(input bit drain);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: y = $urandom_range(0, 32767);
            4, 5:       y = $urandom_range(1580, 2420);
            6, 7:       y = $urandom_range(0, 327) * 100 + $urandom_range(0, 2) - 1;
            default:    y = $urandom_range(32600, 32767);
        endcase
        y = y & 32'h7FFF;
        if ($urandom_range(0, 6) == 0) begin
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end else begin
            m = $urandom_range(1, MONTH_DEC);
            d = $urandom_range(1, days_in_month(m, y));
            if ($urandom_range(0, 3) == 0)
                d = ($urandom_range(0, 1) == 0) ? 1 : days_in_month(m, y);
        end
        case ($urandom_range(0, 9))
            0:          n = 0;
            1, 2:       n = $urandom_range(0, 40);
            3, 4:       n = $urandom_range(0, 800);
            5:          n = $urandom_range(32700, 32767);
            default:    n = $urandom_range(0, 32767);
        endcase
        queue_date(y, m, d, n, drain);
    endtask

    // Stimulus, reset and end of run
    initial begin
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        error_count = 0;

        // Extremes, leap edges, bad dates and every start month
        queue_date(0, 1, 1, 0, 1'b0);
        queue_date(0, 2, 29, 1, 1'b0);
        queue_date(1900, 2, 29, 5, 1'b0);
        queue_date(2000, 2, 29, 365, 1'b0);
        queue_date(2024, 2, 29, 0, 1'b0);
        queue_date(2023, 12, 31, 1, 1'b1);
        queue_date(1999, 12, 31, 366, 1'b0);
        queue_date(32767, 12, 31, 32767, 1'b0);
        queue_date(32767, 12, 31, 0, 1'b0);
        queue_date(32767, 1, 1, 32767, 1'b0);
        queue_date(2100, 2, 28, 1, 1'b0);
        queue_date(2400, 2, 28, 1, 1'b0);
        queue_date(2024, 0, 15, 10, 1'b0);
        queue_date(2024, 13, 1, 10, 1'b0);
        queue_date(32767, 15, 31, 32767, 1'b0);
        queue_date(2024, 3, 0, 10, 1'b0);
        queue_date(2024, 4, 31, 1, 1'b0);
        queue_date(2024, 6, 30, 30, 1'b0);
        queue_date(2024, 5, 31, 31, 1'b0);
        queue_date(2024, 7, 31, 62, 1'b0);
        queue_date(2024, 8, 31, 30, 1'b0);
        queue_date(2024, 9, 30, 31, 1'b0);
        queue_date(2024, 10, 31, 30, 1'b0);
        queue_date(2024, 11, 30, 31, 1'b0);

        for (int i = 0; i < RANDOM_DATES; i++)
            queue_random_date(i % 350 == 175);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || expected_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_dates.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Driver: present pending requests, each after its drawn gap with tvalid low
    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            held_cycles = 0;
            requests_taken = 0;
        end else begin
            // log the request taken at this edge
            if (s_axis_tvalid && s_axis_tready) begin
                expected_dates.push_back(date_after_days(on_bus));
                expected_dates[$].seq = requests_taken;
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (held_cycles < pending[0].gap) begin
                    held_cycles++;
                    s_axis_tvalid <= 1'b0;
                end else if (pending[0].drain && expected_dates.size() != 0) begin
                    // hold until every outstanding result has come back
                    s_axis_tvalid <= 1'b0;
                end else begin
                    on_bus = pending.pop_front();
                    held_cycles = 0;
                    s_axis_tdata  <= {1'b0, on_bus.days, on_bus.day, on_bus.month, on_bus.year};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expected date, then stall
    always @(posedge clk) begin
        date_result_t want;
        logic [YEAR_OUT_W-1:0] got_year;
        logic [MONTH_W-1:0]    got_month;
        logic [DAY_W-1:0]      got_day;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_year  = m_axis_tdata[15:0];
                got_month = m_axis_tdata[19:16];
                got_day   = m_axis_tdata[24:20];
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result %0d-%0d-%0d with no request outstanding",
                                              got_year, got_month, got_day));
                end else begin
                    want = expected_dates.pop_front();
                    if (got_year !== want.year)
                        report_mismatch($sformatf("request %0d end_year %0d, want %0d",
                                                  want.seq, got_year, want.year));
                    if (got_month !== want.month)
                        report_mismatch($sformatf("request %0d end_month %0d, want %0d",
                                                  want.seq, got_month, want.month));
                    if (got_day !== want.day)
                        report_mismatch($sformatf("request %0d end_day %0d, want %0d",
                                                  want.seq, got_day, want.day));
                    if (m_axis_tuser !== want.bad)
                        report_mismatch($sformatf("request %0d bad_input %0b, want %0b",
                                                  want.seq, m_axis_tuser, want.bad));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = ~recv_quiet;
                stall_left = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Watchdog: stop when nothing moves on either side for too long
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
